### rtl/core/hfrf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfrf_pkg: shared definitions for the flash report framer
// Command codes, register indexes, report layout constants, the control and
// status bundles between the controller and the datapath, and the CRC step.
// ----------------------------------------------------------------------------
package hfrf_pkg;

  // Width of the image length register and the sent-byte counter.
  localparam int LENGTH_WIDTH = 24;
  // Configuration data is as wide as the widest register.
  localparam int CFG_DATA_W   = (LENGTH_WIDTH > 8) ? LENGTH_WIDTH : 8;

  // Input command codes.
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_RESP  = 2'd2;
  localparam logic [1:0] CMD_ABORT = 2'd3;

  // Configuration register indexes.
  localparam logic REG_REPORT_ID    = 1'b0;
  localparam logic REG_IMAGE_LENGTH = 1'b1;

  // Response status that means the device accepted the report.
  localparam logic [7:0] RESP_OK = 8'h01;

  // Report layout.
  localparam int REPORT_BYTES = 32;
  localparam int DATA_FIRST   = 11;
  localparam int DATA_BYTES   = 16;
  localparam int DATA_LAST    = DATA_FIRST + DATA_BYTES - 1;
  localparam int CRC_LO_POS   = DATA_LAST + 1;
  localparam int CRC_HI_POS   = DATA_LAST + 2;

  // Header bytes of the start report.
  localparam logic [7:0] HDR_B0 = 8'hF0;
  localparam logic [7:0] HDR_B1 = 8'h0B;
  localparam logic [7:0] HDR_B2 = 8'h01;
  localparam logic [7:0] HDR_B3 = 8'h09;
  localparam logic [7:0] HDR_B4 = 8'h05;
  localparam logic [7:0] HDR_B5 = 8'h04;
  localparam logic [7:0] HDR_B6 = 8'h52;
  localparam logic [7:0] HDR_B7 = 8'h28;
  localparam logic [7:0] HDR_B8 = 8'h00;
  localparam logic [7:0] HDR_B9 = 8'h01;
  localparam logic [7:0] HDR_B10 = 8'hFF;

  // Length bytes of a data report.
  localparam logic [7:0] DATA_LEN4 = 8'(20 + 3);
  localparam logic [7:0] DATA_LEN3 = DATA_LEN4 + 8'd4;
  localparam logic [7:0] DATA_LEN1 = DATA_LEN3 + 8'd2;

  // End report marker and fill.
  localparam logic [7:0] END_MARK = 8'h02;
  localparam logic [7:0] PAD_BYTE = 8'hFF;

  // CRC-16/MODBUS.
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       start;       // reload header, clear counters
    logic       set_abort;   // mark an abort request
    logic       seq_load;    // good response, open a new chunk
    logic       end_load;    // good response, build the end report
    logic       byte_store;  // store one image byte
    logic       emit_byte;   // load one report byte into the output register
    logic [4:0] emit_pos;    // position of that byte within the report
    logic       data_rep;    // the report being sent is a data report
    logic       emit_last;   // that byte ends the run
    logic       emit_finish; // load the finish item into the output register
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic more_data; // bytes remain and no abort is pending
    logic fill_done; // the byte being stored closes the chunk
    logic out_free;  // the output register can take an item this cycle
  } stat_t;

  // One byte of the reflected CRC, bit by bit, low bit first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    logic [7:0]  d;
    logic        x;
    c = crc_in;
    d = data;
    for (int b = 0; b < 8; b++) begin
      x = c[0] ^ d[0];
      c = {1'b0, c[15:1]};
      if (x) begin
        c = c ^ CRC_POLY;
      end
      d = {1'b0, d[7:1]};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/core/hfrf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfrf_ctrl: transfer controller
// Decodes each accepted item against the transfer phase and sequences the
// output of a report, a finish item, or both.
// ----------------------------------------------------------------------------
module hfrf_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire  [1:0]           command,
  input  wire                  resp_full,
  input  wire  [7:0]           resp_status,
  input  wire hfrf_pkg::stat_t stat,
  output hfrf_pkg::ctrl_t      ctrl
);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EMIT   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  // Transfer phases.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_FILL = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [4:0] pos;
  logic [4:0] pos_next;
  logic       then_finish;
  logic       then_finish_next;
  logic       data_rep;
  logic       data_rep_next;
  logic       accept;
  logic       resp_good;
  logic       pos_end;

  assign accept    = in_valid && (state == ST_IDLE);
  assign in_stall  = (state != ST_IDLE);
  assign resp_good = resp_full && (resp_status == hfrf_pkg::RESP_OK);
  assign pos_end   = (pos == 5'(hfrf_pkg::REPORT_BYTES - 1));

  // Item decode and output sequencing.
  always_comb begin
    ctrl             = '0;
    state_next       = state;
    phase_next       = phase;
    pos_next         = pos;
    then_finish_next = then_finish;
    data_rep_next    = data_rep;
    ctrl.emit_pos    = pos;
    ctrl.data_rep    = data_rep;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (command)
            hfrf_pkg::CMD_START: begin
              ctrl.start       = 1'b1;
              phase_next       = PH_WAIT;
              state_next       = ST_EMIT;
              pos_next         = '0;
              then_finish_next = 1'b0;
              data_rep_next    = 1'b0;
            end
            hfrf_pkg::CMD_ABORT: begin
              ctrl.set_abort = 1'b1;
            end
            hfrf_pkg::CMD_RESP: begin
              if (phase == PH_WAIT) begin
                if (!resp_good) begin
                  phase_next = PH_IDLE;
                  state_next = ST_FINISH;
                end else if (stat.more_data) begin
                  ctrl.seq_load = 1'b1;
                  phase_next    = PH_FILL;
                end else begin
                  ctrl.end_load    = 1'b1;
                  phase_next       = PH_IDLE;
                  state_next       = ST_EMIT;
                  pos_next         = '0;
                  then_finish_next = 1'b1;
                  data_rep_next    = 1'b0;
                end
              end
            end
            hfrf_pkg::CMD_BYTE: begin
              if (phase == PH_FILL) begin
                ctrl.byte_store = 1'b1;
                if (stat.fill_done) begin
                  phase_next       = PH_WAIT;
                  state_next       = ST_EMIT;
                  pos_next         = '0;
                  then_finish_next = 1'b0;
                  data_rep_next    = 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          ctrl.emit_byte = 1'b1;
          ctrl.emit_last = pos_end && !then_finish;
          pos_next       = pos + 5'd1;
          if (pos_end) begin
            state_next = then_finish ? ST_FINISH : ST_IDLE;
          end
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          ctrl.emit_finish = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Controller registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= PH_IDLE;
      pos         <= '0;
      then_finish <= 1'b0;
      data_rep    <= 1'b0;
    end else begin
      state       <= state_next;
      phase       <= phase_next;
      pos         <= pos_next;
      then_finish <= then_finish_next;
      data_rep    <= data_rep_next;
    end
  end

endmodule
`default_nettype wire

### rtl/core/hfrf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hfrf_datapath: report buffer, counters, CRC and output register
// Holds the variable bytes of the report, builds each report byte by its
// position, runs the CRC over the sequence bytes and the data region as they
// go out, and drives the output channel.
// ----------------------------------------------------------------------------
module hfrf_datapath (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire                              cfg_index,
  input  wire  [hfrf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire  [7:0]                       file_byte,
  input  wire  [7:0]                       resp_seq_lo,
  input  wire  [7:0]                       resp_seq_hi,
  input  wire hfrf_pkg::ctrl_t             ctrl,
  output hfrf_pkg::stat_t                  stat,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             kind,
  output logic [7:0]                       frame_byte,
  output logic                             last,
  output logic                             success
);

  localparam int LW = hfrf_pkg::LENGTH_WIDTH;

  logic [7:0]    report_id;
  logic [LW-1:0] image_length;
  logic [LW-1:0] bytes_sent;
  logic [LW-1:0] sent_next;
  logic [3:0]    fill_pos;
  logic          abort_pending;
  logic          long_hdr;
  logic [7:0]    seq_lo;
  logic [7:0]    seq_hi;
  logic [7:0]    data_mem [hfrf_pkg::DATA_BYTES];
  logic [15:0]   data_valid;
  logic          data_pad;
  logic [15:0]   crc_acc;
  logic [15:0]   crc_store;
  logic [5:0]    buf_idx;
  logic [5:0]    data_off;
  logic [3:0]    data_idx;
  logic [7:0]    pad_val;
  logic [7:0]    buf_byte;
  logic          in_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      report_id    <= '0;
      image_length <= '0;
    end else if (cfg_we) begin
      if (cfg_index == hfrf_pkg::REG_REPORT_ID) begin
        report_id <= cfg_data[7:0];
      end else begin
        image_length <= cfg_data[LW-1:0];
      end
    end
  end

  // Status toward the controller.
  assign sent_next      = (bytes_sent == {LW{1'b1}}) ? bytes_sent : bytes_sent + 1'b1;
  assign stat.more_data = !abort_pending && (bytes_sent < image_length);
  assign stat.fill_done = (fill_pos == 4'(hfrf_pkg::DATA_BYTES - 1))
                          || (sent_next >= image_length);
  assign stat.out_free  = !out_valid || !out_stall;

  // Buffer position of the byte being sent; a nonzero report id skips byte 0.
  assign buf_idx  = {1'b0, ctrl.emit_pos} + {5'b0, (report_id != 8'd0)};
  assign data_off = buf_idx - 6'(hfrf_pkg::DATA_FIRST);
  assign data_idx = data_off[3:0];
  assign pad_val  = data_pad ? hfrf_pkg::PAD_BYTE : 8'h00;
  assign in_data  = (buf_idx >= 6'(hfrf_pkg::DATA_FIRST))
                    && (buf_idx <= 6'(hfrf_pkg::DATA_LAST));

  // Report byte selection by position.
  always_comb begin
    buf_byte = 8'h00;
    if (in_data) begin
      buf_byte = data_valid[data_idx] ? data_mem[data_idx] : pad_val;
    end else begin
      case (buf_idx)
        6'd0:  buf_byte = hfrf_pkg::HDR_B0;
        6'd1:  buf_byte = long_hdr ? hfrf_pkg::DATA_LEN1 : hfrf_pkg::HDR_B1;
        6'd2:  buf_byte = hfrf_pkg::HDR_B2;
        6'd3:  buf_byte = long_hdr ? hfrf_pkg::DATA_LEN3 : hfrf_pkg::HDR_B3;
        6'd4:  buf_byte = long_hdr ? hfrf_pkg::DATA_LEN4 : hfrf_pkg::HDR_B4;
        6'd5:  buf_byte = hfrf_pkg::HDR_B5;
        6'd6:  buf_byte = hfrf_pkg::HDR_B6;
        6'd7:  buf_byte = hfrf_pkg::HDR_B7;
        6'd8:  buf_byte = hfrf_pkg::HDR_B8;
        6'd9:  buf_byte = seq_lo;
        6'd10: buf_byte = seq_hi;
        6'(hfrf_pkg::CRC_LO_POS): buf_byte = ctrl.data_rep ? crc_acc[7:0] : crc_store[7:0];
        6'(hfrf_pkg::CRC_HI_POS): buf_byte = crc_store[15:8];
        default: buf_byte = 8'h00;
      endcase
    end
  end

  // Data region storage: one byte written per item, read by output position.
  always_ff @(posedge clk) begin
    if (ctrl.byte_store) begin
      data_mem[fill_pos] <= file_byte;
    end
  end

  // Variable report bytes.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      seq_lo <= hfrf_pkg::HDR_B9;
      seq_hi <= hfrf_pkg::HDR_B10;
    end else if (ctrl.seq_load) begin
      seq_lo <= resp_seq_lo;
      seq_hi <= resp_seq_hi;
    end else if (ctrl.end_load) begin
      seq_lo <= hfrf_pkg::END_MARK;
      seq_hi <= hfrf_pkg::PAD_BYTE;
    end
  end

  // Transfer counters, flags and CRC.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_sent    <= '0;
      fill_pos      <= '0;
      abort_pending <= 1'b0;
      long_hdr      <= 1'b0;
      data_valid    <= '0;
      data_pad      <= 1'b0;
      crc_acc       <= hfrf_pkg::CRC_INIT;
      crc_store     <= '0;
    end else begin
      if (ctrl.start) begin
        bytes_sent    <= '0;
        fill_pos      <= '0;
        abort_pending <= 1'b0;
        long_hdr      <= 1'b0;
        data_valid    <= '0;
        data_pad      <= 1'b0;
        crc_store     <= '0;
      end
      if (ctrl.set_abort) begin
        abort_pending <= 1'b1;
      end
      if (ctrl.seq_load || ctrl.end_load) begin
        data_valid <= '0;
        data_pad   <= 1'b1;
        fill_pos   <= '0;
      end
      if (ctrl.byte_store) begin
        data_valid[fill_pos] <= 1'b1;
        bytes_sent           <= sent_next;
        if (stat.fill_done) begin
          fill_pos <= '0;
          long_hdr <= 1'b1;
          crc_acc  <= hfrf_pkg::CRC_INIT;
        end else begin
          fill_pos <= fill_pos + 4'd1;
        end
      end
      // The CRC follows the sequence bytes and the data region as they are sent.
      if (ctrl.emit_byte && ctrl.data_rep) begin
        if ((buf_idx >= 6'd9) && (buf_idx <= 6'(hfrf_pkg::DATA_LAST))) begin
          crc_acc <= hfrf_pkg::crc_byte(crc_acc, buf_byte);
        end
        if (buf_idx == 6'(hfrf_pkg::CRC_LO_POS)) begin
          crc_store <= crc_acc;
        end
      end
      if (ctrl.emit_finish) begin
        bytes_sent <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit_byte || ctrl.emit_finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_byte) begin
      kind       <= 1'b0;
      frame_byte <= buf_byte;
      last       <= ctrl.emit_last;
      success    <= 1'b0;
    end else if (ctrl.emit_finish) begin
      kind       <= 1'b1;
      frame_byte <= 8'h00;
      last       <= 1'b1;
      success    <= (bytes_sent >= image_length);
    end
  end

endmodule
`default_nettype wire

### rtl/core/hid_flash_report_framer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hid_flash_report_framer_core: firmware image to HID report framer
// Builds 32-byte start, data and end reports from a byte stream and the
// device's responses, and signals the end of each transfer.
// ----------------------------------------------------------------------------
// Items are taken one at a time: the input stalls while results are being
// sent. An abort, an ignored item, a good response that opens a new chunk,
// and an image byte that does not close a chunk leave the input free. An
// item that produces a report holds the input while the report goes out,
// one report byte per cycle from a single output register while the output
// does not stall, and the end case then sends the finish item; a refused
// response holds it while its finish item is sent. A stalled output holds
// the input longer. A chunk holds up to 16 image bytes. The CRC takes one
// sequence or data byte per cycle as it goes out, unless the output stalls.
// ----------------------------------------------------------------------------
module hid_flash_report_framer_core (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [1:0]                       command,
  input  wire  [7:0]                       file_byte,
  input  wire                              resp_full,
  input  wire  [7:0]                       resp_status,
  input  wire  [7:0]                       resp_seq_lo,
  input  wire  [7:0]                       resp_seq_hi,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             kind,
  output logic [7:0]                       frame_byte,
  output logic                             last,
  output logic                             success,
  input  wire                              cfg_we,
  input  wire                              cfg_index,
  input  wire  [hfrf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  hfrf_pkg::ctrl_t ctrl;
  hfrf_pkg::stat_t stat;

  // Controller: item decode and output sequencing.
  hfrf_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .resp_full   (resp_full),
    .resp_status (resp_status),
    .stat        (stat),
    .ctrl        (ctrl)
  );

  // Datapath: buffer, counters, CRC and output register.
  hfrf_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .file_byte   (file_byte),
    .resp_seq_lo (resp_seq_lo),
    .resp_seq_hi (resp_seq_hi),
    .ctrl        (ctrl),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .frame_byte  (frame_byte),
    .last        (last),
    .success     (success)
  );

endmodule
`default_nettype wire
